[sv/stack_calculator_macros.svh]
// Assertion helpers shared by the stack calculator RTL.
`ifndef STACK_CALCULATOR_MACROS_SVH
`define STACK_CALCULATOR_MACROS_SVH

`ifndef SYNTHESIS

// General clocked property, checked outside reset.
`define SC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("stack_calculator: property violated");

// Condition that must never hold outside reset.
`define SC_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("stack_calculator: forbidden condition");

`else

`define SC_ASSERT(label, clk, rst, prop)
`define SC_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

[sv/sc_pkg.sv]
`timescale 1ns / 1ps

package sc_pkg;

   localparam int DATA_W  = 32;
   localparam int OP_W    = 3;
   localparam int POS_W   = 10;
   localparam int STS_W   = 3;
   localparam int DEPTH_W = 11;

   // opcodes
   localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
   localparam logic [OP_W-1:0] OP_POP    = 3'd1;
   localparam logic [OP_W-1:0] OP_ADD    = 3'd2;
   localparam logic [OP_W-1:0] OP_SUB    = 3'd3;
   localparam logic [OP_W-1:0] OP_MUL    = 3'd4;
   localparam logic [OP_W-1:0] OP_DIV    = 3'd5;
   localparam logic [OP_W-1:0] OP_RD_TOP = 3'd6;
   localparam logic [OP_W-1:0] OP_RD_BOT = 3'd7;

   // status codes
   localparam logic [STS_W-1:0] STS_OK    = 3'd0;
   localparam logic [STS_W-1:0] STS_FEW   = 3'd1;
   localparam logic [STS_W-1:0] STS_RANGE = 3'd2;
   localparam logic [STS_W-1:0] STS_DIV0  = 3'd3;
   localparam logic [STS_W-1:0] STS_FULL  = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_LOAD,
      S_FETCH2,
      S_EXEC,
      S_DIV,
      S_WRITE,
      S_RESP
   } state_type;

   typedef struct packed {
      logic        [OP_W-1:0]   opcode;
      logic signed [DATA_W-1:0] push_value;
      logic        [POS_W-1:0]  position;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  result_value;
      logic        [STS_W-1:0]   status;
      logic        [DEPTH_W-1:0] depth;
   } rsp_type;

endpackage

[sv/sc_ram.sv]
`timescale 1ns / 1ps

// Generic simple dual-port RAM, one write port, one registered read port.
module sc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/sc_div.sv]
`timescale 1ns / 1ps

`include "stack_calculator_macros.svh"

// Radix-2 restoring divider on magnitudes, floor-corrected at the output.
module sc_div
   import sc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic              done,
   output logic [DATA_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DATA_W);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [DATA_W-1:0] q_ff;
   logic [DATA_W-1:0] rem_ff;
   logic [DATA_W-1:0] den_ff;
   logic              neg_ff;

   logic [DATA_W-1:0] num_abs;
   logic [DATA_W-1:0] den_abs;
   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   trial;
   logic              q_bit;
   logic [DATA_W-1:0] rem_in;

   assign num_abs = dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
   assign den_abs = divisor[DATA_W-1]  ? (~divisor + DATA_W'(1))  : divisor;

   // one quotient bit per cycle
   assign shifted = {rem_ff, q_ff[DATA_W-1]};
   assign trial   = shifted - {1'b0, den_ff};
   assign q_bit   = ~trial[DATA_W];
   assign rem_in  = q_bit ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + CNT_W'(1);
            if (count_ff == CNT_W'(DATA_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= num_abs;
         den_ff <= den_abs;
         rem_ff <= '0;
         neg_ff <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
      end else if (busy_ff) begin
         q_ff   <= {q_ff[DATA_W-2:0], q_bit};
         rem_ff <= rem_in;
      end
   end

   // opposite signs: negate, and step down once more on a nonzero remainder
   assign quotient = !neg_ff        ? q_ff :
                     (rem_ff != '0) ? ~q_ff : (~q_ff + DATA_W'(1));
   assign done     = done_ff;

   `SC_ASSERT_NEVER(a_div_start_busy, clock, reset, start && busy_ff)
   `SC_ASSERT(a_div_done_idle, clock, reset, done_ff |-> !busy_ff)
   `SC_ASSERT(a_div_busy_start, clock, reset, $rose(busy_ff) |-> $past(start))

endmodule

[sv/stack_calculator.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_ready   req_payload (req_type)
// rsp_      out        rsp_valid/rsp_ready   rsp_payload (rsp_type)
//
// Divide waits on the bit-serial divider. The single RAM read port makes binary
// operations fetch their two operands one after the other. Requests are taken
// only in S_IDLE, one at a time. Reset clears the depth, state and response
// valid; RAM contents stay unknown and only entries below the depth are ever
// read. A stalled rsp_ready holds the result register; one more request is
// taken and parks in S_RESP.

`include "stack_calculator_macros.svh"

module stack_calculator
   import sc_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);        // count holds DEPTH itself
   localparam int MW = (CW > POS_W) ? CW : POS_W; // common width for range check

   // control state
   state_type state_ff, state_in;
   logic [CW-1:0] depth_ff, depth_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [OP_W-1:0]   op_ff;
   logic [DATA_W-1:0] val_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [DATA_W-1:0] top_ff, top_in;
   logic [DATA_W-1:0] res_ff, res_in;
   logic [STS_W-1:0]  status_ff, status_in;
   rsp_type           rsp_ff;

   logic capture;
   logic rsp_load;

   // stack RAM
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;

   // divider
   logic              div_start;
   logic              div_done;
   logic [DATA_W-1:0] div_quotient;

   // derived depth terms
   logic [CW-1:0]     depth_m1;
   logic [CW-1:0]     depth_m2;
   logic [CW-1:0]     top_idx;
   logic              full;
   logic              few2;
   logic              in_range;
   logic [DATA_W-1:0] product;

   assign depth_m1 = depth_ff - CW'(1);
   assign depth_m2 = depth_ff - CW'(2);
   assign top_idx  = depth_m1 - CW'(pos_ff);   // only used when in range
   assign full     = (depth_ff == CW'(DEPTH));
   assign few2     = (depth_ff < CW'(2));
   assign in_range = (MW'(pos_ff) < MW'(depth_ff));

   // low word of the product; registered in res_ff
   assign product  = ram_rd_data * top_ff;

   sc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // second operand is the dividend, top entry the divisor
   sc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ram_rd_data),
      .divisor  (top_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         op_ff  <= req_payload.opcode;
         val_ff <= req_payload.push_value;
         pos_ff <= req_payload.position;
      end
      top_ff    <= top_in;
      res_ff    <= res_in;
      status_ff <= status_in;
      if (rsp_load) begin
         rsp_ff.result_value <= res_ff;
         rsp_ff.status       <= status_ff;
         rsp_ff.depth        <= DEPTH_W'(depth_ff);  // depth modulo 2^11
      end
   end

   // Sequencer. Writes land in S_DISPATCH or S_WRITE and the next read is
   // issued no earlier than the following request's dispatch, so a read
   // never overlaps a pending write to the same entry.
   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      top_in       = top_ff;
      res_in       = res_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_load     = 1'b0;
      capture      = 1'b0;
      req_ready    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = AW'(depth_ff);
      ram_wr_data  = val_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = AW'(depth_m1);
      div_start    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               capture  = 1'b1;
               state_in = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            res_in    = '0;
            status_in = STS_OK;
            unique case (op_ff) inside
               OP_PUSH: begin
                  state_in = S_RESP;
                  if (full) begin
                     status_in = STS_FULL;
                  end else begin
                     ram_wr_en = 1'b1;
                     depth_in  = depth_ff + CW'(1);
                  end
               end
               OP_POP: begin
                  if (depth_ff == '0) begin
                     status_in = STS_FEW;
                     state_in  = S_RESP;
                  end else begin
                     ram_rd_en = 1'b1;
                     depth_in  = depth_m1;
                     state_in  = S_LOAD;
                  end
               end
               OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                  if (few2) begin
                     status_in = STS_FEW;
                     state_in  = S_RESP;
                  end else begin
                     ram_rd_en = 1'b1;     // fetch top
                     state_in  = S_FETCH2;
                  end
               end
               OP_RD_TOP, OP_RD_BOT: begin
                  if (!in_range) begin
                     status_in = STS_RANGE;
                     state_in  = S_RESP;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = (op_ff == OP_RD_TOP) ? AW'(top_idx) : AW'(pos_ff);
                     state_in    = S_LOAD;
                  end
               end
            endcase
         end

         S_LOAD: begin
            res_in   = ram_rd_data;
            state_in = S_RESP;
         end

         S_FETCH2: begin
            top_in      = ram_rd_data;
            ram_rd_en   = 1'b1;             // fetch second
            ram_rd_addr = AW'(depth_m2);
            state_in    = S_EXEC;
         end

         S_EXEC: begin
            depth_in = depth_m2;           // both operands popped
            state_in = S_WRITE;
            case (op_ff)
               OP_ADD: res_in = ram_rd_data + top_ff;
               OP_SUB: res_in = ram_rd_data - top_ff;
               OP_MUL: res_in = product;
               default: begin
                  if (top_ff == '0) begin
                     status_in = STS_DIV0;  // nothing pushed back
                     state_in  = S_RESP;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end
            endcase
         end

         S_DIV: begin
            if (div_done) begin
               res_in   = div_quotient;
               state_in = S_WRITE;
            end
         end

         S_WRITE: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = res_ff;
            depth_in    = depth_ff + CW'(1);
            state_in    = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `SC_ASSERT(a_depth_bound, clock, reset, depth_ff <= CW'(DEPTH))
   `SC_ASSERT(a_rsp_from_resp, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
   `SC_ASSERT(a_write_states, clock, reset, ram_wr_en |-> (state_ff == S_DISPATCH || state_ff == S_WRITE))
   `SC_ASSERT(a_div0_only_div, clock, reset, (state_ff == S_RESP && status_ff == STS_DIV0) |-> (op_ff == OP_DIV))

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import sc_pkg::*;

   localparam int STACK_ENTRIES  = 1024;
   localparam int DIRECTED_COUNT = 25;
   localparam int RANDOM_ITEMS   = 160;

   // One directed step: the request, and the result where it is plain enough
   // to be typed in. Rows with typed_check clear go to the stack predictor.
   typedef struct {
      logic        [OP_W-1:0]    opcode;
      logic signed [DATA_W-1:0]  value;
      logic        [POS_W-1:0]   position;
      bit                        typed_check;
      logic signed [DATA_W-1:0]  exp_value;
      logic        [STS_W-1:0]   exp_status;
      logic        [DEPTH_W-1:0] exp_depth;
   } directed_row_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   // Shadow copy of the stack, updated on every accepted request.
   logic signed [DATA_W-1:0] shadow_stack [STACK_ENTRIES];
   int                       shadow_depth = 0;

   // Results still owed by the block, oldest first.
   rsp_type pending_results[$];
   rsp_type wanted;
   int unsigned error_count = 0;

   // Sender idles at random unless this is cleared.
   bit          sender_gaps   = 1'b1;
   int unsigned requests_sent = 0;

   // Receiver-side bookkeeping, kept in its own process.
   int unsigned results_taken  = 0;
   int unsigned hold_cycles    = 0;
   bit          long_hold_done = 1'b0;

   directed_row_type directed_rows [DIRECTED_COUNT];

   stack_calculator #(
      .DEPTH(STACK_ENTRIES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Stack predictor: applies one request to the shadow stack and returns
   // the result the block must give for it.
   // ---------------------------------------------------------------------
   function automatic rsp_type execute_request(input req_type r);
      rsp_type                  res;
      logic signed [DATA_W-1:0] top_entry;
      logic signed [DATA_W-1:0] next_entry;
      longint                   quotient;
      longint                   remainder;
      res = '0;
      res.status = STS_OK;
      case (r.opcode)
         OP_PUSH: begin
            if (shadow_depth >= STACK_ENTRIES) begin
               res.status = STS_FULL;
            end else begin
               shadow_stack[shadow_depth] = r.push_value;
               shadow_depth++;
            end
         end
         OP_POP: begin
            if (shadow_depth == 0) begin
               res.status = STS_FEW;
            end else begin
               shadow_depth--;
               res.result_value = shadow_stack[shadow_depth];
            end
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (shadow_depth < 2) begin
               res.status = STS_FEW;
            end else begin
               top_entry  = shadow_stack[shadow_depth - 1];
               next_entry = shadow_stack[shadow_depth - 2];
               shadow_depth -= 2;
               case (r.opcode)
                  OP_ADD: res.result_value = next_entry + top_entry;
                  OP_SUB: res.result_value = next_entry - top_entry;
                  OP_MUL: res.result_value = next_entry * top_entry;
                  default: begin
                     if (top_entry == 0) begin
                        // operands stay popped, nothing goes back
                        res.status = STS_DIV0;
                     end else begin
                        // 64-bit math so that -2^31 / -1 is exact before
                        // it wraps back to 32 bits
                        quotient  = longint'(next_entry) / longint'(top_entry);
                        remainder = longint'(next_entry) % longint'(top_entry);
                        if (remainder != 0 && ((next_entry < 0) != (top_entry < 0)))
                           quotient--;
                        res.result_value = quotient[DATA_W-1:0];
                     end
                  end
               endcase
               if (res.status == STS_OK) begin
                  shadow_stack[shadow_depth] = res.result_value;
                  shadow_depth++;
               end
            end
         end
         OP_RD_TOP, OP_RD_BOT: begin
            if (int'(r.position) >= shadow_depth)
               res.status = STS_RANGE;
            else if (r.opcode == OP_RD_TOP)
               res.result_value = shadow_stack[shadow_depth - 1 - int'(r.position)];
            else
               res.result_value = shadow_stack[r.position];
         end
      endcase
      res.depth = shadow_depth[DEPTH_W-1:0];
      return res;
   endfunction

   function automatic req_type make_request(input logic [OP_W-1:0] op,
                                            input logic signed [DATA_W-1:0] value,
                                            input logic [POS_W-1:0] pos);
      req_type r;
      r.opcode     = op;
      r.push_value = value;
      r.position   = pos;
      return r;
   endfunction

   // Operand values lean on the corners: zero, one, minus one, both extremes.
   function automatic logic signed [DATA_W-1:0] random_value();
      case ($urandom_range(7))
         0: return 32'sd0;
         1: return 32'sd1;
         2: return -32'sd1;
         3: return 32'h8000_0000;
         4: return 32'h7FFF_FFFF;
         5: return DATA_W'(int'($urandom_range(200)) - 100);
         default: return $urandom;
      endcase
   endfunction

   // Single random request. Push share falls as the stack grows so the depth
   // wanders between empty and a few dozen entries.
   function automatic req_type random_request();
      req_type     r;
      int unsigned push_pct;
      r.push_value = random_value();
      r.position   = POS_W'($urandom_range(1023));
      push_pct = (shadow_depth < 6) ? 45 : (shadow_depth < 30) ? 30 : 15;
      if ($urandom_range(99) < push_pct)
         r.opcode = OP_PUSH;
      else
         r.opcode = OP_W'($urandom_range(7));
      // reads mostly land inside the stack, the rest probe out of range
      if ((r.opcode == OP_RD_TOP || r.opcode == OP_RD_BOT) && shadow_depth > 0 &&
          $urandom_range(3) != 0)
         r.position = POS_W'($urandom_range(shadow_depth - 1));
      return r;
   endfunction

   // Drive one request, hold it until accepted, then log its expected result.
   // Requests 500 to 799 go out with no idle cycles between them.
   task automatic issue_request(input req_type item, input bit use_typed,
                                input rsp_type typed_result);
      rsp_type modeled;
      sender_gaps = !(requests_sent >= 500 && requests_sent < 800);
      if (sender_gaps) begin
         while ($urandom_range(99) < 26) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
      modeled = execute_request(item);
      pending_results.push_back(use_typed ? typed_result : modeled);
   endtask

   // ---------------------------------------------------------------------
   // Receiver: random back-pressure, one long hold-off early on so the block
   // fills up and stalls its input, and a stretch with ready held high.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready)
         results_taken <= results_taken + 1;
      if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready   <= 1'b0;
      end else if (!long_hold_done && results_taken == 200) begin
         long_hold_done <= 1'b1;
         hold_cycles    <= 300;
         rsp_ready      <= 1'b0;
      end else if (results_taken >= 500 && results_taken < 800) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 26);
      end
   end

   // Result checker: every accepted result against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: value %0d status %0d depth %0d",
                   rsp_payload.result_value, rsp_payload.status, rsp_payload.depth);
            error_count++;
         end else begin
            wanted = pending_results.pop_front();
            if (rsp_payload.result_value !== wanted.result_value) begin
               $error("result_value: expected %0d, got %0d",
                      wanted.result_value, rsp_payload.result_value);
               error_count++;
            end
            if (rsp_payload.status !== wanted.status) begin
               $error("status: expected %0d, got %0d", wanted.status, rsp_payload.status);
               error_count++;
            end
            if (rsp_payload.depth !== wanted.depth) begin
               $error("depth: expected %0d, got %0d", wanted.depth, rsp_payload.depth);
               error_count++;
            end
         end
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int      count;
      bit      paused;
      req_type item;
      rsp_type typed;

      // Directed walk from an empty stack: faults on empty, extremes, every
      // opcode, divide by zero, and the -2^31 / -1 wrap.
      directed_rows = '{
         '{OP_POP,    32'sd0,        10'd0,    1'b1, 32'sd0,        STS_FEW,   11'd0},
         '{OP_ADD,    32'sd0,        10'd0,    1'b1, 32'sd0,        STS_FEW,   11'd0},
         '{OP_RD_TOP, 32'sd0,        10'd0,    1'b1, 32'sd0,        STS_RANGE, 11'd0},
         '{OP_RD_BOT, 32'sd0,        10'd1023, 1'b1, 32'sd0,        STS_RANGE, 11'd0},
         '{OP_PUSH,   32'h7FFF_FFFF, 10'd0,    1'b1, 32'sd0,        STS_OK,    11'd1},
         '{OP_DIV,    32'sd0,        10'd0,    1'b1, 32'sd0,        STS_FEW,   11'd1},
         '{OP_PUSH,   32'h8000_0000, 10'd0,    1'b1, 32'sd0,        STS_OK,    11'd2},
         '{OP_RD_TOP, 32'sd0,        10'd0,    1'b1, 32'h8000_0000, STS_OK,    11'd2},
         '{OP_RD_BOT, 32'sd0,        10'd0,    1'b1, 32'h7FFF_FFFF, STS_OK,    11'd2},
         '{OP_RD_TOP, 32'sd0,        10'd2,    1'b1, 32'sd0,        STS_RANGE, 11'd2},
         '{OP_ADD,    32'sd0,        10'd0,    1'b1, 32'hFFFF_FFFF, STS_OK,    11'd1},
         '{OP_PUSH,   32'hFFFF_FFFF, 10'd0,    1'b1, 32'sd0,        STS_OK,    11'd2},
         '{OP_MUL,    32'sd0,        10'd0,    1'b1, 32'sd1,        STS_OK,    11'd1},
         '{OP_PUSH,   32'sd0,        10'd0,    1'b1, 32'sd0,        STS_OK,    11'd2},
         '{OP_DIV,    32'sd0,        10'd0,    1'b1, 32'sd0,        STS_DIV0,  11'd0},
         '{OP_PUSH,   32'h8000_0000, 10'd0,    1'b1, 32'sd0,        STS_OK,    11'd1},
         '{OP_PUSH,   32'hFFFF_FFFF, 10'd0,    1'b1, 32'sd0,        STS_OK,    11'd2},
         '{OP_DIV,    32'sd0,        10'd0,    1'b1, 32'h8000_0000, STS_OK,    11'd1},
         '{OP_PUSH,   32'sd7,        10'd0,    1'b1, 32'sd0,        STS_OK,    11'd2},
         '{OP_SUB,    32'sd0,        10'd0,    1'b1, 32'h7FFF_FFF9, STS_OK,    11'd1},
         '{OP_PUSH,   -32'sd7,       10'd0,    1'b1, 32'sd0,        STS_OK,    11'd2},
         '{OP_PUSH,   32'sd2,        10'd0,    1'b1, 32'sd0,        STS_OK,    11'd3},
         '{OP_DIV,    32'sd0,        10'd0,    1'b0, 32'sd0,        STS_OK,    11'd0},
         '{OP_MUL,    32'sd0,        10'd0,    1'b0, 32'sd0,        STS_OK,    11'd0},
         '{OP_POP,    32'sd0,        10'd0,    1'b0, 32'sd0,        STS_OK,    11'd0}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         item  = make_request(directed_rows[i].opcode, directed_rows[i].value,
                              directed_rows[i].position);
         typed = '{directed_rows[i].exp_value, directed_rows[i].exp_status,
                   directed_rows[i].exp_depth};
         issue_request(item, directed_rows[i].typed_check, typed);
      end

      // Random part: mostly push-push-operate-readback groups, the rest
      // single random requests that hit faults and odd indexes.
      count  = 0;
      paused = 1'b0;
      while (count < RANDOM_ITEMS) begin
         if (!paused && count >= 100) begin
            // let the block drain completely before carrying on
            paused = 1'b1;
            req_valid <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
         end
         if ($urandom_range(9) < 4) begin
            issue_request(make_request(OP_PUSH, random_value(), POS_W'($urandom)), 1'b0, '0);
            issue_request(make_request(OP_PUSH, random_value(), POS_W'($urandom)), 1'b0, '0);
            issue_request(make_request(OP_W'($urandom_range(OP_ADD, OP_DIV)),
                                       random_value(), POS_W'($urandom)), 1'b0, '0);
            if ($urandom_range(1) == 0)
               issue_request(make_request(OP_RD_TOP, random_value(), 10'd0), 1'b0, '0);
            else
               issue_request(make_request(OP_POP, random_value(), POS_W'($urandom)), 1'b0, '0);
            count += 4;
         end else begin
            issue_request(random_request(), 1'b0, '0);
            count++;
         end
      end

      // Fill the stack to the brim, then poke at the full boundary.
      while (shadow_depth < STACK_ENTRIES)
         issue_request(make_request(OP_PUSH, random_value(), POS_W'($urandom)), 1'b0, '0);
      issue_request(make_request(OP_PUSH, random_value(), 10'd0), 1'b1,
                    '{32'sd0, STS_FULL, 11'd1024});
      issue_request(make_request(OP_RD_TOP, 32'sd0, 10'd1023), 1'b0, '0);
      issue_request(make_request(OP_RD_BOT, 32'sd0, 10'd1023), 1'b0, '0);
      issue_request(make_request(OP_RD_BOT, 32'sd0, 10'd0), 1'b0, '0);
      issue_request(make_request(OP_ADD, 32'sd0, 10'd0), 1'b0, '0);
      issue_request(make_request(OP_PUSH, random_value(), 10'd0), 1'b0, '0);
      issue_request(make_request(OP_PUSH, random_value(), 10'd0), 1'b1,
                    '{32'sd0, STS_FULL, 11'd1024});
      issue_request(make_request(OP_POP, 32'sd0, 10'd0), 1'b0, '0);
      issue_request(make_request(OP_DIV, 32'sd0, 10'd0), 1'b0, '0);
      issue_request(make_request(OP_RD_TOP, 32'sd0, 10'd1022), 1'b0, '0);
      req_valid <= 1'b0;

      // Drain, then give the divider time to show any stray result.
      while (pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
